/* design/cubic_bezier_point_curvature_top_assert.svh */
// Assertion macros used by the curvature module cbpc_curv.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef CUBIC_BEZIER_POINT_CURVATURE_TOP_ASSERT_SVH
`define CUBIC_BEZIER_POINT_CURVATURE_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define CBPC_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CBPC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cbpc_pkg.sv */
`default_nettype none
package cbpc_pkg;

   // Fixed field widths.
   localparam int CBPC_FRACTION_BITS = 16;
   localparam int CURVE_PARAM_W      = 17;
   localparam int COORD_W            = 32;
   localparam int CSR_INDEX_W        = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_START_X       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_Y       = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_CTRL_X  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_CTRL_Y  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_CTRL_X = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_CTRL_Y = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_END_X         = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_END_Y         = 4'd7;

   // Curvature datapath widths.
   localparam int NUM_W      = 34;  // 2*|cross|
   localparam int S_W        = 33;  // squared normalized speed
   localparam int E_W        = 6;   // quotient scale exponent
   localparam int ROOT_W     = 25;
   localparam int SQRT_W     = 50;
   localparam int SQRT_STEPS = 25;
   localparam int PROD_W     = S_W + ROOT_W;
   localparam int DEN_W      = PROD_W + 2;
   localparam int REM_W      = DEN_W + 1;
   localparam int DIV_STEPS  = 31;
   localparam int WIDE_W     = REM_W + DIV_STEPS;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] first_ctrl_x;
      logic signed [31:0] first_ctrl_y;
      logic signed [31:0] second_ctrl_x;
      logic signed [31:0] second_ctrl_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } ctrl_pts_type;

   typedef struct packed {
      logic signed [32:0] d0x;
      logic signed [32:0] d0y;
      logic signed [32:0] d1x;
      logic signed [32:0] d1y;
      logic signed [32:0] d2x;
      logic signed [32:0] d2y;
      logic signed [33:0] e0x;
      logic signed [33:0] e0y;
      logic signed [33:0] e1x;
      logic signed [33:0] e1y;
   } ctrl_diff_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               neg;
      logic               zero;
      logic [NUM_W-1:0]   num;
      logic [S_W-1:0]     s;
      logic [E_W-1:0]     e;
   } curv_job_type;

endpackage
`default_nettype wire

/* design/cbpc_geom.sv */
`default_nettype none
module cbpc_geom #(
   parameter int FRACTION_BITS = 16,
   localparam int NW = (FRACTION_BITS + 1 > cbpc_pkg::CURVE_PARAM_W) ?
                       FRACTION_BITS + 1 : cbpc_pkg::CURVE_PARAM_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [NW-1:0]          in_n,
   input  cbpc_pkg::ctrl_pts_type  pts,
   input  cbpc_pkg::ctrl_diff_type diffs,
   output cbpc_pkg::curv_job_type  job_out
);
   import cbpc_pkg::*;

   localparam int PW = 35 + NW + 1;
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRACTION_BITS - 1);

   // Round-half-up linear interpolation a + (b - a) * t.
   function automatic logic signed [33:0] lerp(input logic signed [33:0] a,
                                                input logic signed [33:0] b,
                                                input logic [NW-1:0] n);
      logic signed [34:0]   diff;
      logic signed [PW-1:0] prod;
      diff = 35'(b) - 35'(a);
      prod = PW'(diff) * PW'($signed({1'b0, n}));
      prod = prod + HALF;
      prod = prod >>> FRACTION_BITS;
      return a + 34'(prod);
   endfunction

   function automatic logic [33:0] mag34(input logic signed [33:0] x);
      return (x < 0) ? 34'(-x) : 34'(x);
   endfunction

   // Shift that brings the larger magnitude below 2^16.
   function automatic logic [4:0] norm_shift(input logic [33:0] m);
      logic [5:0] len;
      len = '0;
      for (int i = 0; i < 34; i++) begin
         if (m[i]) begin
            len = 6'(i + 1);
         end
      end
      return (len > 6'd16) ? 5'(len - 6'd16) : 5'd0;
   endfunction

   // Stage 1: first de Casteljau level for the point and both derivatives.
   logic               s1_valid_ff;
   logic [NW-1:0]      s1_n_ff;
   logic signed [31:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff, s1_cx_ff, s1_cy_ff;
   logic signed [32:0] s1_ux_ff, s1_uy_ff, s1_wx_ff, s1_wy_ff;
   logic signed [33:0] s1_lx_ff, s1_ly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_n_ff  <= in_n;
         s1_ax_ff <= 32'(lerp(34'(pts.start_x), 34'(pts.first_ctrl_x), in_n));
         s1_ay_ff <= 32'(lerp(34'(pts.start_y), 34'(pts.first_ctrl_y), in_n));
         s1_bx_ff <= 32'(lerp(34'(pts.first_ctrl_x), 34'(pts.second_ctrl_x), in_n));
         s1_by_ff <= 32'(lerp(34'(pts.first_ctrl_y), 34'(pts.second_ctrl_y), in_n));
         s1_cx_ff <= 32'(lerp(34'(pts.second_ctrl_x), 34'(pts.end_x), in_n));
         s1_cy_ff <= 32'(lerp(34'(pts.second_ctrl_y), 34'(pts.end_y), in_n));
         s1_ux_ff <= 33'(lerp(34'(diffs.d0x), 34'(diffs.d1x), in_n));
         s1_uy_ff <= 33'(lerp(34'(diffs.d0y), 34'(diffs.d1y), in_n));
         s1_wx_ff <= 33'(lerp(34'(diffs.d1x), 34'(diffs.d2x), in_n));
         s1_wy_ff <= 33'(lerp(34'(diffs.d1y), 34'(diffs.d2y), in_n));
         s1_lx_ff <= lerp(diffs.e0x, diffs.e1x, in_n);
         s1_ly_ff <= lerp(diffs.e0y, diffs.e1y, in_n);
      end
   end

   // Stage 2: second level; the first derivative is complete here.
   logic               s2_valid_ff;
   logic [NW-1:0]      s2_n_ff;
   logic signed [31:0] s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;
   logic signed [32:0] s2_qx_ff, s2_qy_ff;
   logic signed [33:0] s2_lx_ff, s2_ly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_n_ff  <= s1_n_ff;
         s2_ax_ff <= 32'(lerp(34'(s1_ax_ff), 34'(s1_bx_ff), s1_n_ff));
         s2_ay_ff <= 32'(lerp(34'(s1_ay_ff), 34'(s1_by_ff), s1_n_ff));
         s2_bx_ff <= 32'(lerp(34'(s1_bx_ff), 34'(s1_cx_ff), s1_n_ff));
         s2_by_ff <= 32'(lerp(34'(s1_by_ff), 34'(s1_cy_ff), s1_n_ff));
         s2_qx_ff <= 33'(lerp(34'(s1_ux_ff), 34'(s1_wx_ff), s1_n_ff));
         s2_qy_ff <= 33'(lerp(34'(s1_uy_ff), 34'(s1_wy_ff), s1_n_ff));
         s2_lx_ff <= s1_lx_ff;
         s2_ly_ff <= s1_ly_ff;
      end
   end

   // Stage 3: curve point.
   logic               s3_valid_ff;
   logic signed [31:0] s3_px_ff, s3_py_ff;
   logic signed [32:0] s3_qx_ff, s3_qy_ff;
   logic signed [33:0] s3_lx_ff, s3_ly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_px_ff <= 32'(lerp(34'(s2_ax_ff), 34'(s2_bx_ff), s2_n_ff));
         s3_py_ff <= 32'(lerp(34'(s2_ay_ff), 34'(s2_by_ff), s2_n_ff));
         s3_qx_ff <= s2_qx_ff;
         s3_qy_ff <= s2_qy_ff;
         s3_lx_ff <= s2_lx_ff;
         s3_ly_ff <= s2_ly_ff;
      end
   end

   // Stage 4: magnitudes and normalizing shifts.
   logic               s4_valid_ff;
   logic signed [31:0] s4_px_ff, s4_py_ff;
   logic [33:0]        s4_mqx_ff, s4_mqy_ff, s4_mlx_ff, s4_mly_ff;
   logic               s4_nqx_ff, s4_nqy_ff, s4_nlx_ff, s4_nly_ff;
   logic [4:0]         s4_kq_ff, s4_kl_ff;
   logic               s4_zero_ff;
   logic [33:0]        mqx, mqy, mlx, mly;

   always_comb begin
      mqx = mag34(34'(s3_qx_ff));
      mqy = mag34(34'(s3_qy_ff));
      mlx = mag34(s3_lx_ff);
      mly = mag34(s3_ly_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_px_ff   <= s3_px_ff;
         s4_py_ff   <= s3_py_ff;
         s4_mqx_ff  <= mqx;
         s4_mqy_ff  <= mqy;
         s4_mlx_ff  <= mlx;
         s4_mly_ff  <= mly;
         s4_nqx_ff  <= s3_qx_ff < 0;
         s4_nqy_ff  <= s3_qy_ff < 0;
         s4_nlx_ff  <= s3_lx_ff < 0;
         s4_nly_ff  <= s3_ly_ff < 0;
         s4_kq_ff   <= norm_shift((mqx > mqy) ? mqx : mqy);
         s4_kl_ff   <= norm_shift((mlx > mly) ? mlx : mly);
         s4_zero_ff <= (s3_qx_ff == 0) && (s3_qy_ff == 0);
      end
   end

   // Stage 5: truncate toward zero to 16-bit magnitudes; quotient exponent.
   logic               s5_valid_ff;
   logic signed [31:0] s5_px_ff, s5_py_ff;
   logic signed [16:0] s5_qx_ff, s5_qy_ff, s5_lx_ff, s5_ly_ff;
   logic [E_W-1:0]     s5_e_ff;
   logic               s5_zero_ff;
   logic [15:0]        tqx, tqy, tlx, tly;
   logic [E_W-1:0]     e_in;
   int                 e_raw;

   always_comb begin
      tqx   = 16'(s4_mqx_ff >> s4_kq_ff);
      tqy   = 16'(s4_mqy_ff >> s4_kq_ff);
      tlx   = 16'(s4_mlx_ff >> s4_kl_ff);
      tly   = 16'(s4_mly_ff >> s4_kl_ff);
      e_raw = 40 + int'(s4_kl_ff) - 2 * int'(s4_kq_ff);
      e_in  = (e_raw < 0) ? '0 : E_W'(e_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_px_ff   <= s4_px_ff;
         s5_py_ff   <= s4_py_ff;
         s5_qx_ff   <= s4_nqx_ff ? -$signed({1'b0, tqx}) : $signed({1'b0, tqx});
         s5_qy_ff   <= s4_nqy_ff ? -$signed({1'b0, tqy}) : $signed({1'b0, tqy});
         s5_lx_ff   <= s4_nlx_ff ? -$signed({1'b0, tlx}) : $signed({1'b0, tlx});
         s5_ly_ff   <= s4_nly_ff ? -$signed({1'b0, tly}) : $signed({1'b0, tly});
         s5_e_ff    <= e_in;
         s5_zero_ff <= s4_zero_ff;
      end
   end

   // Stage 6: cross and square products.
   logic               s6_valid_ff;
   logic signed [31:0] s6_px_ff, s6_py_ff;
   logic signed [33:0] s6_c1_ff, s6_c2_ff, s6_sx_ff, s6_sy_ff;
   logic [E_W-1:0]     s6_e_ff;
   logic               s6_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_px_ff   <= s5_px_ff;
         s6_py_ff   <= s5_py_ff;
         s6_c1_ff   <= s5_qx_ff * s5_ly_ff;
         s6_c2_ff   <= s5_qy_ff * s5_lx_ff;
         s6_sx_ff   <= s5_qx_ff * s5_qx_ff;
         s6_sy_ff   <= s5_qy_ff * s5_qy_ff;
         s6_e_ff    <= s5_e_ff;
         s6_zero_ff <= s5_zero_ff;
      end
   end

   // Stage 7: cross product, squared speed and quotient numerator.
   curv_job_type       job_ff;
   logic signed [34:0] cross_val;
   logic [32:0]        cross_mag;

   always_comb begin
      cross_val = 35'(s6_c1_ff) - 35'(s6_c2_ff);
      cross_mag = (cross_val < 0) ? 33'(-cross_val) : 33'(cross_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else if (advance) begin
         job_ff.valid   <= s6_valid_ff;
         job_ff.point_x <= s6_px_ff;
         job_ff.point_y <= s6_py_ff;
         job_ff.neg     <= cross_val < 0;
         job_ff.zero    <= s6_zero_ff;
         job_ff.num     <= {cross_mag, 1'b0};
         job_ff.s       <= S_W'(s6_sx_ff + s6_sy_ff);
         job_ff.e       <= s6_e_ff;
      end
   end

   assign job_out = job_ff;

endmodule
`default_nettype wire

/* design/cbpc_curv.sv */
`default_nettype none
`include "cubic_bezier_point_curvature_top_assert.svh"
module cbpc_curv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cbpc_pkg::curv_job_type job_in,
   output logic                  out_valid,
   output logic signed [31:0]    out_point_x,
   output logic signed [31:0]    out_point_y,
   output logic signed [31:0]    out_curvature,
   output logic                  out_speed_zero
);
   import cbpc_pkg::*;

   // Square root of s * 2^16, one result bit per stage.
   curv_job_type      sq_job_ff  [SQRT_STEPS];
   logic [SQRT_W-1:0] sq_rem_ff  [SQRT_STEPS];
   logic [SQRT_W-1:0] sq_root_ff [SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
      curv_job_type      job_prev;
      logic [SQRT_W-1:0] rem_prev, root_prev, trial, rem_in, root_in;

      if (i == 0) begin : g_head
         assign job_prev  = job_in;
         assign rem_prev  = SQRT_W'(job_in.s) << 16;
         assign root_prev = '0;
      end else begin : g_tail
         assign job_prev  = sq_job_ff[i-1];
         assign rem_prev  = sq_rem_ff[i-1];
         assign root_prev = sq_root_ff[i-1];
      end

      always_comb begin
         trial = root_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_job_ff[i].valid <= 1'b0;
         end else if (advance) begin
            sq_job_ff[i]  <= job_prev;
            sq_rem_ff[i]  <= rem_in;
            sq_root_ff[i] <= root_in;
         end
      end
   end

   // Speed product s * M, and the scaled numerator split at the quotient's top bit.
   curv_job_type       sq_last;
   logic [SQRT_W-1:0]  root_last;
   curv_job_type       m_job_ff;
   logic [PROD_W-1:0]  m_prod_ff;
   logic [REM_W-1:0]   m_hi_ff;
   logic [DIV_STEPS-1:0] m_lo_ff;
   logic [WIDE_W-1:0]  wide;

   assign sq_last   = sq_job_ff[SQRT_STEPS-1];
   assign root_last = sq_root_ff[SQRT_STEPS-1];
   assign wide      = WIDE_W'(sq_last.num) << sq_last.e;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_job_ff.valid <= 1'b0;
      end else if (advance) begin
         m_job_ff  <= sq_last;
         m_prod_ff <= PROD_W'(sq_last.s) * PROD_W'(root_last[ROOT_W-1:0]);
         m_hi_ff   <= wide[WIDE_W-1:DIV_STEPS];
         m_lo_ff   <= wide[DIV_STEPS-1:0];
      end
   end

   // Denominator 3 * s * M.
   curv_job_type         d_job_ff;
   logic [DEN_W-1:0]     d_den_ff;
   logic [REM_W-1:0]     d_hi_ff;
   logic [DIV_STEPS-1:0] d_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_job_ff.valid <= 1'b0;
      end else if (advance) begin
         d_job_ff <= m_job_ff;
         d_den_ff <= DEN_W'(m_prod_ff) + DEN_W'({m_prod_ff, 1'b0});
         d_hi_ff  <= m_hi_ff;
         d_lo_ff  <= m_lo_ff;
      end
   end

   // Overflow check: the quotient reaches 2^31 when the high part is not below the denominator.
   curv_job_type         z_job_ff;
   logic [DEN_W-1:0]     z_den_ff;
   logic [REM_W-1:0]     z_rem_ff;
   logic [DIV_STEPS-1:0] z_lo_ff;
   logic                 z_sat_ff;
   logic                 sat_in;

   assign sat_in = d_hi_ff >= REM_W'(d_den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         z_job_ff.valid <= 1'b0;
      end else if (advance) begin
         z_job_ff <= d_job_ff;
         z_den_ff <= d_den_ff;
         z_rem_ff <= sat_in ? '0 : d_hi_ff;
         z_lo_ff  <= d_lo_ff;
         z_sat_ff <= sat_in;
      end
   end

   // Restoring division, one quotient bit per stage.
   curv_job_type         dv_job_ff [DIV_STEPS];
   logic [DEN_W-1:0]     dv_den_ff [DIV_STEPS];
   logic [REM_W-1:0]     dv_rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_lo_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_q_ff   [DIV_STEPS];
   logic                 dv_sat_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      curv_job_type         job_prev;
      logic [DEN_W-1:0]     den_prev;
      logic [REM_W-1:0]     rem_prev, trial, rem_in;
      logic [DIV_STEPS-1:0] lo_prev, q_prev, q_in;
      logic                 sat_prev, fits;

      if (i == 0) begin : g_head
         assign job_prev = z_job_ff;
         assign den_prev = z_den_ff;
         assign rem_prev = z_rem_ff;
         assign lo_prev  = z_lo_ff;
         assign q_prev   = '0;
         assign sat_prev = z_sat_ff;
      end else begin : g_tail
         assign job_prev = dv_job_ff[i-1];
         assign den_prev = dv_den_ff[i-1];
         assign rem_prev = dv_rem_ff[i-1];
         assign lo_prev  = dv_lo_ff[i-1];
         assign q_prev   = dv_q_ff[i-1];
         assign sat_prev = dv_sat_ff[i-1];
      end

      always_comb begin
         trial  = {rem_prev[REM_W-2:0], lo_prev[DIV_STEPS-1-i]};
         fits   = trial >= REM_W'(den_prev);
         rem_in = fits ? trial - REM_W'(den_prev) : trial;
         q_in   = {q_prev[DIV_STEPS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_job_ff[i].valid <= 1'b0;
         end else if (advance) begin
            dv_job_ff[i] <= job_prev;
            dv_den_ff[i] <= den_prev;
            dv_rem_ff[i] <= rem_in;
            dv_lo_ff[i]  <= lo_prev;
            dv_q_ff[i]   <= q_in;
            dv_sat_ff[i] <= sat_prev;
         end
      end
   end

   // Output register: sign, saturation and the zero-speed case.
   curv_job_type       last_job;
   logic [REM_W-1:0]   rem_last;
   logic [DEN_W-1:0]   den_last;
   logic signed [31:0] curv_in;

   assign last_job = dv_job_ff[DIV_STEPS-1];
   assign rem_last = dv_rem_ff[DIV_STEPS-1];
   assign den_last = dv_den_ff[DIV_STEPS-1];

   always_comb begin
      if (last_job.zero) begin
         curv_in = '0;
      end else if (dv_sat_ff[DIV_STEPS-1]) begin
         curv_in = last_job.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (last_job.neg) begin
         curv_in = -$signed({1'b0, dv_q_ff[DIV_STEPS-1]});
      end else begin
         curv_in = $signed({1'b0, dv_q_ff[DIV_STEPS-1]});
      end
   end

   logic               out_valid_ff;
   logic signed [31:0] out_point_x_ff, out_point_y_ff, out_curvature_ff;
   logic               out_speed_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last_job.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_point_x_ff    <= last_job.point_x;
         out_point_y_ff    <= last_job.point_y;
         out_curvature_ff  <= curv_in;
         out_speed_zero_ff <= last_job.zero;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_point_x    = out_point_x_ff;
   assign out_point_y    = out_point_y_ff;
   assign out_curvature  = out_curvature_ff;
   assign out_speed_zero = out_speed_zero_ff;

   // A nonzero speed gives s >= 1, so the root of s * 2^16 is at least 256.
   `CBPC_ASSERT_IMPLY(a_root_floor, sq_last.valid && !sq_last.zero, root_last >= SQRT_W'(256), "speed root below its lower bound")
   // The division remainder always stays below the denominator.
   `CBPC_ASSERT_IMPLY(a_rem_below_den, last_job.valid && !last_job.zero, rem_last < REM_W'(den_last), "division remainder not reduced")
   // A zero-speed result carries a zero curvature.
   `CBPC_ASSERT_IMPLY(a_zero_curv, out_valid_ff && out_speed_zero_ff, out_curvature_ff == 0, "zero speed with nonzero curvature")

endmodule
`default_nettype wire

/* design/cubic_bezier_point_curvature_top.sv */
`default_nettype none
// Cubic Bezier evaluator: for each curve parameter t (unsigned, 2^FRACTION_BITS is 1.0,
// larger values clamp to 1.0) it returns the curve point and the signed curvature of
// the curve held in the eight control-point registers, all in signed Q16.16, with a
// flag when the speed is zero. It is a fully pipelined datapath that takes one
// transaction every clock cycle unless the output stalls; each result passes through
// 1 input stage, 7 geometry stages, 25 square-root stages, 3 denominator stages,
// 31 divider stages and 1 output register. The whole pipeline halts while a result
// waits on rsp_tready. Write the control points only while no transaction is in flight.
module cubic_bezier_point_curvature_top #(
   parameter int FRACTION_BITS = cbpc_pkg::CBPC_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cbpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // [16:0] curve_param
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [95:0]                      rsp_tdata,   // point_x, point_y, curvature
   output logic [0:0]                       rsp_tuser    // speed_zero
);
   import cbpc_pkg::*;

   localparam int NW = (FRACTION_BITS + 1 > CURVE_PARAM_W) ? FRACTION_BITS + 1 : CURVE_PARAM_W;
   localparam logic [NW-1:0] ONE = NW'(1) << FRACTION_BITS;

   // Control point registers.
   ctrl_pts_type pts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_X:       pts_ff.start_x       <= csr_wdata;
            REG_START_Y:       pts_ff.start_y       <= csr_wdata;
            REG_FIRST_CTRL_X:  pts_ff.first_ctrl_x  <= csr_wdata;
            REG_FIRST_CTRL_Y:  pts_ff.first_ctrl_y  <= csr_wdata;
            REG_SECOND_CTRL_X: pts_ff.second_ctrl_x <= csr_wdata;
            REG_SECOND_CTRL_Y: pts_ff.second_ctrl_y <= csr_wdata;
            REG_END_X:         pts_ff.end_x         <= csr_wdata;
            REG_END_Y:         pts_ff.end_y         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // First and second control-point differences, refreshed every cycle.
   ctrl_diff_type diffs_ff, diffs_in;

   always_comb begin
      diffs_in.d0x = 33'(pts_ff.first_ctrl_x) - 33'(pts_ff.start_x);
      diffs_in.d0y = 33'(pts_ff.first_ctrl_y) - 33'(pts_ff.start_y);
      diffs_in.d1x = 33'(pts_ff.second_ctrl_x) - 33'(pts_ff.first_ctrl_x);
      diffs_in.d1y = 33'(pts_ff.second_ctrl_y) - 33'(pts_ff.first_ctrl_y);
      diffs_in.d2x = 33'(pts_ff.end_x) - 33'(pts_ff.second_ctrl_x);
      diffs_in.d2y = 33'(pts_ff.end_y) - 33'(pts_ff.second_ctrl_y);
      diffs_in.e0x = 34'(pts_ff.second_ctrl_x) - 34'(pts_ff.first_ctrl_x)
                   - 34'(pts_ff.first_ctrl_x) + 34'(pts_ff.start_x);
      diffs_in.e0y = 34'(pts_ff.second_ctrl_y) - 34'(pts_ff.first_ctrl_y)
                   - 34'(pts_ff.first_ctrl_y) + 34'(pts_ff.start_y);
      diffs_in.e1x = 34'(pts_ff.end_x) - 34'(pts_ff.second_ctrl_x)
                   - 34'(pts_ff.second_ctrl_x) + 34'(pts_ff.first_ctrl_x);
      diffs_in.e1y = 34'(pts_ff.end_y) - 34'(pts_ff.second_ctrl_y)
                   - 34'(pts_ff.second_ctrl_y) + 34'(pts_ff.first_ctrl_y);
   end

   always_ff @(posedge clock) begin
      diffs_ff <= diffs_in;
   end

   // The pipeline moves whenever the output register is free or being drained.
   logic advance;
   logic out_valid;

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   // Input stage with parameter clamp.
   logic          n0_valid_ff;
   logic [NW-1:0] n0_ff, n_raw, n_in;

   always_comb begin
      n_raw = NW'(req_tdata[CURVE_PARAM_W-1:0]);
      n_in  = (n_raw > ONE) ? ONE : n_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n0_valid_ff <= 1'b0;
      end else if (advance) begin
         n0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n0_ff <= n_in;
      end
   end

   curv_job_type       job;
   logic signed [31:0] out_point_x, out_point_y, out_curvature;
   logic               out_speed_zero;

   cbpc_geom #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (n0_valid_ff),
      .in_n     (n0_ff),
      .pts      (pts_ff),
      .diffs    (diffs_ff),
      .job_out  (job)
   );

   cbpc_curv u_curv (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .job_in         (job),
      .out_valid      (out_valid),
      .out_point_x    (out_point_x),
      .out_point_y    (out_point_y),
      .out_curvature  (out_curvature),
      .out_speed_zero (out_speed_zero)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {out_curvature, out_point_y, out_point_x};
   assign rsp_tuser  = out_speed_zero;

endmodule
`default_nettype wire

/* sim/cubic_bezier_point_curvature_top_test.sv */
`default_nettype none
module cubic_bezier_point_curvature_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cbpc_pkg::*;

   localparam int FRAC = CBPC_FRACTION_BITS;
   localparam logic [16:0] T_ONE = 17'h10000;
   localparam int LATENCY = 68;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] curvature;
      logic               speed_zero;
   } curve_sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;   // [16:0] curve_param
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [95:0]            rsp_tdata;        // point_x, point_y, curvature
   logic [0:0]             rsp_tuser;        // speed_zero

   // Local copy of the control points.
   logic signed [31:0] ctrl_pts [8];

   curve_sample_type expected_samples [$];
   int  mismatch_count = 0;
   int  sample_count = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;
   bit  holding = 1'b0;
   bit  drain_done = 1'b0;

   cubic_bezier_point_curvature_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Interpolation with round half up.
   function automatic longint blend(longint a, longint b, longint n);
      longint d;
      d = (b - a) * n + (longint'(1) << (FRAC - 1));
      return a + (d >>> FRAC);
   endfunction

   function automatic int unsigned fit_shift(longint a, longint b);
      longint unsigned m;
      longint unsigned ma;
      longint unsigned mb;
      int unsigned k;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m = ma > mb ? ma : mb;
      k = 0;
      while ((m >> k) >= 64'h10000) k++;
      return k;
   endfunction

   function automatic longint shrink(longint x, int unsigned k);
      longint unsigned m;
      m = (x < 0 ? -x : x);
      m = m >> k;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Computes the point and curvature for one curve parameter.
   function automatic curve_sample_type eval_curve(logic [16:0] t_raw);
      curve_sample_type res;
      longint n, ax, ay, bx, by, cx, cy, px, py;
      longint d0x, d0y, d1x, d1y, d2x, d2y, qx, qy, lx, ly;
      longint sqx, sqy, slx, sly, c;
      longint p [8];
      longint unsigned s, m, den, num, q, r;
      int unsigned kq, kl;
      int e;
      bit sat;
      for (int i = 0; i < 8; i++) p[i] = ctrl_pts[i];
      n = t_raw > T_ONE ? T_ONE : t_raw;
      ax = blend(p[0], p[2], n); ay = blend(p[1], p[3], n);
      bx = blend(p[2], p[4], n); by = blend(p[3], p[5], n);
      cx = blend(p[4], p[6], n); cy = blend(p[5], p[7], n);
      ax = blend(ax, bx, n); ay = blend(ay, by, n);
      bx = blend(bx, cx, n); by = blend(by, cy, n);
      px = blend(ax, bx, n); py = blend(ay, by, n);
      d0x = p[2] - p[0]; d0y = p[3] - p[1];
      d1x = p[4] - p[2]; d1y = p[5] - p[3];
      d2x = p[6] - p[4]; d2y = p[7] - p[5];
      qx = blend(blend(d0x, d1x, n), blend(d1x, d2x, n), n);
      qy = blend(blend(d0y, d1y, n), blend(d1y, d2y, n), n);
      lx = blend(d1x - d0x, d2x - d1x, n);
      ly = blend(d1y - d0y, d2y - d1y, n);
      res.point_x = px[31:0];
      res.point_y = py[31:0];
      res.speed_zero = (qx == 0 && qy == 0);
      res.curvature = '0;
      if (!res.speed_zero) begin
         kq = fit_shift(qx, qy);
         kl = fit_shift(lx, ly);
         sqx = shrink(qx, kq); sqy = shrink(qy, kq);
         slx = shrink(lx, kl); sly = shrink(ly, kl);
         c = sqx * sly - sqy * slx;
         s = sqx * sqx + sqy * sqy;
         m = int_sqrt(s << 16);
         den = 3 * s * m;
         num = 2 * (c < 0 ? -c : c);
         e = 40 + int'(kl) - 2 * int'(kq);
         if (e < 0) e = 0;
         q = num / den;
         r = num % den;
         sat = q >= 64'h8000_0000;
         for (int i = 0; i < e && !sat; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
               r -= den;
               q |= 1;
            end
            if (q >= 64'h8000_0000) sat = 1'b1;
         end
         if (sat) q = 64'h8000_0000;
         if (c < 0) res.curvature = -q;
         else res.curvature = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
      end
      return res;
   endfunction

   // Writes one control-point register; indexes above the last are ignored.
   // The write enable stays high until finish_writes drops it.
   task automatic write_point_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx <= REG_END_Y) ctrl_pts[idx] = val;
   endtask

   task automatic finish_writes();
      csr_we <= 1'b0;
   endtask

   task automatic load_curve(logic [31:0] pts [8]);
      for (int i = 0; i < 8; i++) write_point_reg(i[CSR_INDEX_W-1:0], pts[i]);
      finish_writes();
   endtask

   // Sends one transaction and records its expected result.
   task automatic send_param(logic [16:0] t_raw);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, t_raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_samples.insert(expected_samples.size(), eval_curve(t_raw));
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clock);
   endtask

   // Waits for all results, then lets the pipeline empty out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [16:0] random_param();
      case ($urandom_range(0, 9))
         0: return T_ONE;
         1: return 17'd0;
         2: return 17'($urandom_range(17'h10001, 17'h1FFFF));
         default: return 17'($urandom_range(0, 17'h10000));
      endcase
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         3: return $urandom();
         default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   // Random parameters in bursts with random gaps.
   task automatic send_random_burst(int count);
      int left;
      left = count;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && left > 0; i++, left--) send_param(random_param());
         if ($urandom_range(0, 2) == 0) pause_sender();
      end
   endtask

   // Parameter extremes, clamping and the ignored register indexes.
   task automatic test_directed_extremes();
      logic [31:0] pts [8];
      pts = '{32'hFFFF_0000, 32'h0, 32'h0000_8000, 32'h0002_0000,
              32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000};
      for (int i = 0; i < 8; i++) write_point_reg(i[CSR_INDEX_W-1:0], pts[i]);
      write_point_reg(4'd9, 32'h1234_5678);
      write_point_reg(4'd15, 32'hFFFF_FFFF);
      finish_writes();
      send_param(17'd0);
      send_param(17'd1);
      send_param(17'h08000);
      send_param(17'hFFFF);
      send_param(T_ONE);
      send_param(17'h10001);
      send_param(17'h1FFFF);
      send_param(17'h15555);
      send_param(17'h0AAAA);
      wait_drained();
   endtask

   // All points equal gives zero speed everywhere; a straight line gives zero curvature.
   task automatic test_degenerate_curves();
      logic [31:0] pts [8];
      pts = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
              32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000};
      load_curve(pts);
      send_param(17'd0); send_param(17'h08000); send_param(T_ONE);
      wait_drained();
      // Cusp: speed vanishes at the midpoint only.
      pts = '{32'h0, 32'h0, 32'h0004_0000, 32'h0004_0000,
              32'h0, 32'h0004_0000, 32'h0004_0000, 32'h0};
      load_curve(pts);
      send_param(17'h08000); send_param(17'h04000);
      pts = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
              32'h0002_0000, 32'h0002_0000, 32'h0003_0000, 32'h0003_0000};
      wait_drained();
      load_curve(pts);
      send_param(17'h04000); send_param(17'h0C000);
      wait_drained();
   endtask

   // Tiny tight curve forces saturation of both signs; full-scale coordinates.
   task automatic test_saturation_extremes();
      logic [31:0] pts [8];
      pts = '{32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h1, 32'h0, 32'h1};
      load_curve(pts);
      send_param(17'h08000); send_param(17'd0);
      wait_drained();
      pts = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0};
      load_curve(pts);
      send_param(17'h08000); send_param(T_ONE);
      wait_drained();
      pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      load_curve(pts);
      send_param(17'd0); send_param(17'h08000); send_param(T_ONE); send_param(17'h1FFFF);
      wait_drained();
   endtask

   // Random curves, random parameters; one longer phase runs with the receiver held off,
   // so that the pipeline fills and the input stalls.
   task automatic test_random_curves();
      logic [31:0] pts [8];
      for (int phase = 0; phase < 16; phase++) begin
         for (int i = 0; i < 8; i++) pts[i] = random_coord();
         load_curve(pts);
         if (phase == 3) begin
            hold_off = 1'b1;
            wait (holding);
         end
         send_random_burst(phase == 3 ? 120 : 44);
         wait_drained();
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) ctrl_pts[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_degenerate_curves();
      test_saturation_extremes();
      test_random_curves();
      drain_done = 1'b1;
   end

   // Receiver backpressure; a long hold-off when requested.
   initial begin
      int stall_len;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            holding = 1'b1;
            repeat (300) @(posedge clock);
            holding = 1'b0;
            hold_off = 1'b0;
         end
         stall_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
         rsp_tready <= stall_len == 0;
         repeat (stall_len == 0 ? $urandom_range(1, 30) : stall_len) @(posedge clock);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      curve_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result transaction %h", rsp_tdata);
         end else begin
            want = expected_samples.pop_front();
            sample_count++;
            if (rsp_tdata[31:0] !== want.point_x || rsp_tdata[63:32] !== want.point_y ||
                rsp_tdata[95:64] !== want.curvature || rsp_tuser[0] !== want.speed_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: exp x=%h y=%h k=%h z=%b got x=%h y=%h k=%h z=%b",
                     want.point_x, want.point_y, want.curvature, want.speed_zero,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0]);
            end
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || !req_tvalid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (drain_done) begin
         $display("Checked %0d results over directed, degenerate, saturating and random curves.",
            sample_count);
         if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("SUCCESS");
         else
            $display("FAILURE");
         $finish;
      end
   end

   // Catches a stall while results are outstanding.
   initial begin
      int waited;
      waited = 0;
      forever begin
         @(posedge clock);
         if (expected_samples.size() != 0 && !(rsp_tvalid && rsp_tready)) waited++;
         else waited = 0;
         if (waited >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
